>>> hdl/svzs_pkg.sv
// package for the surface voxel z-buffer splat block
// holds widths, register indexes, reset values and fixed-point helpers
// no dependencies
package svzs_pkg;

    localparam int IMG_W_DEF     = 256;
    localparam int IMG_H_DEF     = 256;
    localparam int VOL_MAX_DEF   = 256;
    localparam int MAX_SPLAT_DEF = 8;

    localparam int COORD_W = 9;
    localparam int DEPTH_W = 24;
    localparam int PIX_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_DEPTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPLAT_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPLAT_H   = 3'd5;

    localparam logic [63:0] ROW_X_RST     = 64'd4096;
    localparam logic [63:0] ROW_Y_RST     = 64'd268435456;
    localparam logic [63:0] ROW_DEPTH_RST = 64'd17592186044416;
    localparam logic [7:0]  THRESH_RST    = 8'd128;
    localparam logic [15:0] SPLAT_RST     = 16'd4137;

    localparam logic signed [DEPTH_W-1:0] EMPTY_DEPTH = 24'sd262144;

    // command codes
    localparam logic CMD_SPLAT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // stored pixel word
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0]        hx;
        logic [COORD_W-1:0]        hy;
        logic [COORD_W-1:0]        hz;
    } pix_t;

    localparam int PIX_BITS = DEPTH_W + 3*COORD_W;

    // round half away from zero, dropping 12 fractional bits of a 40-bit value
    function automatic logic signed [27:0] round12(input logic signed [39:0] v);
        logic signed [39:0] a;
        logic        [39:0] m;
        begin
            a = v[39] ? -v : v;
            m = (a + 40'sd2048) >>> 12;
            round12 = v[39] ? -m[27:0] : m[27:0];
        end
    endfunction

endpackage

>>> hdl/surface_voxel_zbuffer_splat.sv
// surface voxel z-buffer splat, top level
// a read word passes the READ and RWAIT states to the output register; input reopens once
// it is taken; a non-surface splat leaves the block idle; a surface splat holds the input
// during the 12-term projection through one multiplier, then bounds, then a read and a
// write-back per covered pixel; reset: registers take reset values, then a clearing pass writes
// the empty pixel to every ram entry, input held off; depends on svzs_pkg, svzs_ram, svzs_proj
module surface_voxel_zbuffer_splat #(
    parameter int IMG_W     = svzs_pkg::IMG_W_DEF,
    parameter int IMG_H     = svzs_pkg::IMG_H_DEF,
    parameter int VOL_MAX   = svzs_pkg::VOL_MAX_DEF,
    parameter int MAX_SPLAT = svzs_pkg::MAX_SPLAT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [svzs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [svzs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [svzs_pkg::COORD_W-1:0]        s_vox_x,
    input  logic [svzs_pkg::COORD_W-1:0]        s_vox_y,
    input  logic [svzs_pkg::COORD_W-1:0]        s_vox_z,
    input  logic [7:0]                          s_center_value,
    input  logic [47:0]                         s_neighbor_values,
    input  logic [5:0]                          s_neighbor_present,
    input  logic [svzs_pkg::PIX_W-1:0]          s_pixel_x,
    input  logic [svzs_pkg::PIX_W-1:0]          s_pixel_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [svzs_pkg::DEPTH_W-1:0] m_depth,
    output logic [svzs_pkg::COORD_W-1:0]        m_src_x,
    output logic [svzs_pkg::COORD_W-1:0]        m_src_y,
    output logic [svzs_pkg::COORD_W-1:0]        m_src_z
);

    localparam int NPIX  = IMG_W * IMG_H;
    localparam int AW    = $clog2(NPIX);
    localparam int XW    = $clog2(IMG_W);
    localparam int YW    = $clog2(IMG_H);
    localparam int CW    = AW + 1;
    localparam logic signed [39:0] EXT_LIM = 40'(MAX_SPLAT) <<< 12;

    // states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PROJ  = 3'd2;
    localparam logic [2:0] ST_RECT  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_RWAIT = 3'd7;

    svzs_pkg::pix_t empty_pix;
    assign empty_pix = '{depth: svzs_pkg::EMPTY_DEPTH, hx: '0, hy: '0, hz: '0};

    // configuration registers
    logic [63:0] row_x_reg, row_y_reg, row_d_reg;
    logic [7:0]  thresh_reg;
    logic [15:0] splat_w_reg, splat_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg   <= svzs_pkg::ROW_X_RST;
            row_y_reg   <= svzs_pkg::ROW_Y_RST;
            row_d_reg   <= svzs_pkg::ROW_DEPTH_RST;
            thresh_reg  <= svzs_pkg::THRESH_RST;
            splat_w_reg <= svzs_pkg::SPLAT_RST;
            splat_h_reg <= svzs_pkg::SPLAT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                svzs_pkg::REG_ROW_X:     row_x_reg   <= cfg_data;
                svzs_pkg::REG_ROW_Y:     row_y_reg   <= cfg_data;
                svzs_pkg::REG_ROW_DEPTH: row_d_reg   <= cfg_data;
                svzs_pkg::REG_THRESHOLD: thresh_reg  <= cfg_data[7:0];
                svzs_pkg::REG_SPLAT_W:   splat_w_reg <= cfg_data[15:0];
                svzs_pkg::REG_SPLAT_H:   splat_h_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // surface test on the incoming word
    logic edge_hit;
    logic is_surface;
    always_comb begin
        edge_hit = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (s_neighbor_present[i] && s_neighbor_values[8*i +: 8] < thresh_reg) begin
                edge_hit = 1'b1;
            end
        end
        is_surface = (s_center_value > thresh_reg) && edge_hit;
    end

    // control and working registers
    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         clr_reg, clr_next;
    logic [svzs_pkg::COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [XW-1:0]         pxl_reg;
    logic [YW-1:0]         pyl_reg;
    logic                  rd_oob_reg;
    logic [XW-1:0]         xs_reg, xe_reg, ix_reg, ix_next;
    logic [YW-1:0]         ys_reg, ye_reg, iy_reg, iy_next;
    logic                  rect_empty;
    logic                  rect_bad_reg;
    logic signed [svzs_pkg::DEPTH_W-1:0] d_reg;
    logic                  out_vld_reg;
    svzs_pkg::pix_t        out_reg;

    // projection unit
    logic proj_start, proj_done;
    logic signed [39:0] px, py, pd;
    svzs_proj u_proj (
        .aclk(aclk), .aresetn(aresetn), .start(proj_start),
        .row_x(row_x_reg), .row_y(row_y_reg), .row_d(row_d_reg),
        .vx(vx_reg), .vy(vy_reg), .vz(vz_reg),
        .done(proj_done), .px(px), .py(py), .pd(pd)
    );

    // rectangle bounds and rounded depth from projection results
    logic signed [39:0] wext, hext;
    logic signed [27:0] xs_r, xe_r, ys_r, ye_r;
    logic signed [39:0] pd_abs, pd_rnd_m;
    logic signed [39:0] d_full;
    logic signed [39:0] xs_c, xe_c, ys_c, ye_c;
    always_comb begin
        wext = (40'(splat_w_reg) > EXT_LIM) ? EXT_LIM : 40'(splat_w_reg);
        hext = (40'(splat_h_reg) > EXT_LIM) ? EXT_LIM : 40'(splat_h_reg);
        xs_r = svzs_pkg::round12(px);
        xe_r = svzs_pkg::round12(px + wext);
        ys_r = svzs_pkg::round12(py);
        ye_r = svzs_pkg::round12(py + hext);
        xs_c = (xs_r < 0) ? 40'sd0 : 40'(xs_r);
        ys_c = (ys_r < 0) ? 40'sd0 : 40'(ys_r);
        xe_c = (40'(xe_r) > 40'(IMG_W - 1)) ? 40'(IMG_W - 1) : 40'(xe_r);
        ye_c = (40'(ye_r) > 40'(IMG_H - 1)) ? 40'(IMG_H - 1) : 40'(ye_r);
        pd_abs   = pd[39] ? -pd : pd;
        pd_rnd_m = (pd_abs + 40'sd8) >>> 4;
        d_full   = pd[39] ? -pd_rnd_m : pd_rnd_m;
    end

    // pixel ram
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    svzs_pkg::pix_t        ram_wdata, ram_rdata;
    logic [svzs_pkg::PIX_BITS-1:0] ram_rbits;
    logic [AW-1:0]         cur_addr, rd_addr;

    assign cur_addr = AW'(iy_reg) * AW'(IMG_W) + AW'(ix_reg);
    assign rd_addr  = AW'(pyl_reg) * AW'(IMG_W) + AW'(pxl_reg);
    assign ram_rdata = ram_rbits;

    svzs_ram #(.WIDTH(svzs_pkg::PIX_BITS), .DEPTH(NPIX)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rbits)
    );

    assign s_ready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign rect_empty = ($signed(xs_c) > $signed(xe_c)) || ($signed(ys_c) > $signed(ye_c));

    // next state and ram port control
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        proj_start = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_addr;
        ram_wdata  = empty_pix;
        ram_raddr  = cur_addr;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[AW-1:0];
                clr_next  = clr_reg + CW'(1);
                if (clr_reg == CW'(NPIX - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_cmd == svzs_pkg::CMD_READ) begin
                        state_next = ST_READ;
                    end else if (is_surface) begin
                        state_next = ST_PROJ;
                        proj_start = 1'b1;
                    end
                end
            end
            ST_PROJ: begin
                if (proj_done) begin
                    state_next = ST_RECT;
                end
            end
            ST_RECT: begin
                ix_next = xs_reg;
                iy_next = ys_reg;
                state_next = (xs_reg > xe_reg || ys_reg > ye_reg || rect_bad_reg)
                    ? ST_IDLE : ST_RD;
            end
            ST_RD: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                // compare and write back, then step through the rectangle
                if (d_reg < ram_rdata.depth) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{depth: d_reg, hx: vx_reg, hy: vy_reg, hz: vz_reg};
                end
                if (ix_reg == xe_reg) begin
                    ix_next = xs_reg;
                    if (iy_reg == ye_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        iy_next    = iy_reg + YW'(1);
                        state_next = ST_RD;
                    end
                end else begin
                    ix_next    = ix_reg + XW'(1);
                    state_next = ST_RD;
                end
            end
            ST_READ: begin
                ram_raddr  = rd_addr;
                state_next = ST_RWAIT;
            end
            ST_RWAIT: begin
                ram_waddr = rd_addr;
                ram_we    = !rd_oob_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (state_reg == ST_RWAIT) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ix_reg <= ix_next;
        iy_reg <= iy_next;
        if (s_valid && s_ready) begin
            vx_reg     <= s_vox_x;
            vy_reg     <= s_vox_y;
            vz_reg     <= s_vox_z;
            pxl_reg    <= XW'(s_pixel_x);
            pyl_reg    <= YW'(s_pixel_y);
            rd_oob_reg <= (32'(s_pixel_x) >= IMG_W) || (32'(s_pixel_y) >= IMG_H);
        end
        if (state_reg == ST_PROJ && proj_done) begin
            xs_reg <= xs_c[XW-1:0];
            ys_reg <= ys_c[YW-1:0];
            xe_reg <= (xe_c < 0) ? '0 : xe_c[XW-1:0];
            ye_reg <= (ye_c < 0) ? '0 : ye_c[YW-1:0];
            rect_bad_reg <= rect_empty || xe_c < 0 || ye_c < 0
                || xs_c > 40'(IMG_W - 1) || ys_c > 40'(IMG_H - 1);
            if (d_full > 40'sd8388607) begin
                d_reg <= 24'sd8388607;
            end else if (d_full < -40'sd8388608) begin
                d_reg <= -24'sd8388608;
            end else begin
                d_reg <= d_full[svzs_pkg::DEPTH_W-1:0];
            end
        end
        if (state_reg == ST_RWAIT) begin
            out_reg <= rd_oob_reg ? empty_pix : ram_rdata;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_depth = out_reg.depth;
    assign m_src_x = out_reg.hx;
    assign m_src_y = out_reg.hy;
    assign m_src_z = out_reg.hz;

    // a result only follows a read access
    a_out_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(state_reg) == ST_RWAIT) else $error("stray result");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready) else $error("accept during clear");
    a_wb_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WB |-> $past(state_reg) == ST_RD) else $error("write without read");
    a_rect_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WB |-> ix_reg <= xe_reg && iy_reg <= ye_reg)
        else $error("pixel outside rectangle");

endmodule

>>> hdl/svzs_ram.sv
// generic single-port-write, single-read ram with registered read
// depends on nothing
module svzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/svzs_proj.sv
// projection unit: one row evaluated per pass through a shared multiplier
// depends on svzs_pkg
module svzs_proj (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [63:0]                 row_x,
    input  logic [63:0]                 row_y,
    input  logic [63:0]                 row_d,
    input  logic [svzs_pkg::COORD_W-1:0] vx,
    input  logic [svzs_pkg::COORD_W-1:0] vy,
    input  logic [svzs_pkg::COORD_W-1:0] vz,
    output logic                        done,
    output logic signed [39:0]          px,
    output logic signed [39:0]          py,
    output logic signed [39:0]          pd
);

    // step counter: row in bits [3:2], term in bits [1:0]
    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic signed [39:0] acc_reg, acc_next;
    logic signed [26:0] prod_reg;
    logic               prod_vld_reg;
    logic [1:0]         prod_term_reg;
    logic [1:0]         prod_row_reg;
    logic [63:0]        row_sel;
    logic signed [15:0] coef;
    logic signed [10:0] mul_b;
    logic               done_reg;
    logic signed [39:0] px_reg, py_reg, pd_reg;

    always_comb begin
        case (step_reg[3:2])
            2'd0:    row_sel = row_x;
            2'd1:    row_sel = row_y;
            default: row_sel = row_d;
        endcase
        case (step_reg[1:0])
            2'd0:    begin coef = row_sel[15:0];  mul_b = {2'b00, vx}; end
            2'd1:    begin coef = row_sel[31:16]; mul_b = {2'b00, vy}; end
            2'd2:    begin coef = row_sel[47:32]; mul_b = {2'b00, vz}; end
            default: begin coef = row_sel[63:48]; mul_b = 11'sd256; end
        endcase
    end

    // sequencer over 3 rows x 4 terms
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            if (step_reg == 4'd11) begin
                busy_next = 1'b0;
            end else if (step_reg[1:0] == 2'd3) begin
                step_next = step_reg + 4'd1;
            end else begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    // accumulate registered products
    always_comb begin
        acc_next = acc_reg;
        if (prod_vld_reg) begin
            acc_next = (prod_term_reg == 2'd0) ? 40'(prod_reg) : acc_reg + 40'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            prod_vld_reg <= busy_reg;
            done_reg     <= prod_vld_reg && prod_row_reg == 2'd2 && prod_term_reg == 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= coef * mul_b;
        prod_term_reg <= step_reg[1:0];
        prod_row_reg  <= step_reg[3:2];
        acc_reg       <= acc_next;
        if (prod_vld_reg && prod_term_reg == 2'd3) begin
            case (prod_row_reg)
                2'd0:    px_reg <= acc_next - 40'sd4096;
                2'd1:    py_reg <= acc_next - 40'sd4096;
                default: pd_reg <= acc_next;
            endcase
        end
    end

    assign done = done_reg;
    assign px   = px_reg;
    assign py   = py_reg;
    assign pd   = pd_reg;

    // done marks the end of the third row
    a_done_after_row: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(prod_vld_reg)) else $error("done without product");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("projection restarted while busy");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= 4'd11) else $error("step out of range");

endmodule

>>> dv/surface_voxel_zbuffer_splat_tb.sv
// testbench for surface_voxel_zbuffer_splat: directed table, then random phases
// a z-buffer predictor in the bench checks every read word; depends on svzs_pkg
`timescale 1ns / 100ps
module surface_voxel_zbuffer_splat_tb;

    localparam int IMG_W     = svzs_pkg::IMG_W_DEF;
    localparam int IMG_H     = svzs_pkg::IMG_H_DEF;
    localparam int MAX_SPLAT = svzs_pkg::MAX_SPLAT_DEF;
    localparam int SETTLE    = 300;       // longest surface splat, with margin
    localparam int HOLD_OFF  = 3000;
    localparam longint LIMIT = 3000000;

    typedef struct {
        logic       cmd;
        logic [8:0] vx, vy, vz;
        logic [7:0] cv;
        logic [47:0] nv;
        logic [5:0] np;
        logic [7:0] pxl, pyl;
    } voxel_word_t;

    typedef struct {
        voxel_word_t    w;
        bit             known;
        svzs_pkg::pix_t res;
    } table_row_t;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [svzs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [svzs_pkg::CFG_DATA_W-1:0] cfg_data;
    logic s_valid, s_ready, s_cmd;
    logic [svzs_pkg::COORD_W-1:0] s_vox_x, s_vox_y, s_vox_z;
    logic [7:0] s_center_value;
    logic [47:0] s_neighbor_values;
    logic [5:0] s_neighbor_present;
    logic [svzs_pkg::PIX_W-1:0] s_pixel_x, s_pixel_y;
    logic m_valid, m_ready;
    logic signed [svzs_pkg::DEPTH_W-1:0] m_depth;
    logic [svzs_pkg::COORD_W-1:0] m_src_x, m_src_y, m_src_z;

    surface_voxel_zbuffer_splat i_dut (.*);

    // bench copy of registers and pixel store
    logic [63:0] mdl_reg [6];
    svzs_pkg::pix_t zbuf [IMG_W*IMG_H];
    svzs_pkg::pix_t pending_reads [$];
    table_row_t directed [$];

    int     n_err = 0;
    longint hold_from = -longint'(HOLD_OFF);
    longint cyc = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint coef(logic [63:0] row, int k);
        return longint'($signed(row[16*k +: 16]));
    endfunction

    function automatic longint project(logic [63:0] row, longint x, longint y, longint z);
        return coef(row, 0)*x + coef(row, 1)*y + coef(row, 2)*z + coef(row, 3)*256;
    endfunction

    // round half away from zero
    function automatic longint round_off(longint v, int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (v >= 0) return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint extent(logic [63:0] w);
        longint lim;
        lim = longint'(MAX_SPLAT) << 12;
        return (longint'(w[15:0]) > lim) ? lim : longint'(w[15:0]);
    endfunction

    // z-buffer update for one accepted word; reads return the expected pixel and clear it
    function automatic void zbuf_apply(voxel_word_t w);
        bit on_edge;
        longint px, py, d, xs, xe, ys, ye, idx;
        svzs_pkg::pix_t p;
        logic [7:0] thr;
        thr = mdl_reg[svzs_pkg::REG_THRESHOLD][7:0];
        if (w.cmd == svzs_pkg::CMD_READ) begin
            idx = longint'(w.pxl) + longint'(w.pyl)*IMG_W;
            pending_reads.push_back(zbuf[idx]);
            p.depth = svzs_pkg::EMPTY_DEPTH; p.hx = '0; p.hy = '0; p.hz = '0;
            zbuf[idx] = p;
            return;
        end
        on_edge = 0;
        for (int i = 0; i < 6; i++)
            if (w.np[i] && w.nv[8*i +: 8] < thr) on_edge = 1;
        if (!(w.cv > thr && on_edge)) return;
        px = project(mdl_reg[svzs_pkg::REG_ROW_X], w.vx, w.vy, w.vz) - 4096;
        py = project(mdl_reg[svzs_pkg::REG_ROW_Y], w.vx, w.vy, w.vz) - 4096;
        d  = round_off(project(mdl_reg[svzs_pkg::REG_ROW_DEPTH], w.vx, w.vy, w.vz), 4);
        if (d > 8388607) d = 8388607;
        if (d < -8388608) d = -8388608;
        xs = round_off(px, 12);
        if (xs < 0) xs = 0;
        xe = round_off(px + extent(mdl_reg[svzs_pkg::REG_SPLAT_W]), 12);
        if (xe > IMG_W-1) xe = IMG_W-1;
        ys = round_off(py, 12);
        if (ys < 0) ys = 0;
        ye = round_off(py + extent(mdl_reg[svzs_pkg::REG_SPLAT_H]), 12);
        if (ye > IMG_H-1) ye = IMG_H-1;
        for (longint iy = ys; iy <= ye; iy++)
            for (longint ix = xs; ix <= xe; ix++) begin
                idx = ix + iy*IMG_W;
                if (d < longint'(zbuf[idx].depth)) begin
                    zbuf[idx].depth = d[23:0];
                    zbuf[idx].hx = w.vx;
                    zbuf[idx].hy = w.vy;
                    zbuf[idx].hz = w.vz;
                end
            end
    endfunction

    // clock counter, timeout, receiver stall pattern
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("surface_voxel_zbuffer_splat_tb NOT OK");
            $finish;
        end
        if (cyc - hold_from < longint'(HOLD_OFF)) begin
            m_ready <= 1'b0;
        end else if (cyc[8]) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result word checker
    always @(posedge aclk) begin
        svzs_pkg::pix_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected read word depth %0d", m_depth);
            end else begin
                e = pending_reads.pop_front();
                if (m_depth !== e.depth || m_src_x !== e.hx || m_src_y !== e.hy
                    || m_src_z !== e.hz) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("read mismatch: exp %0d (%0d,%0d,%0d) got %0d (%0d,%0d,%0d)",
                                 e.depth, e.hx, e.hy, e.hz,
                                 m_depth, m_src_x, m_src_y, m_src_z);
                end
            end
        end
    end

    // offer one word and wait until it is taken; valid stays high afterwards
    task automatic send_word(voxel_word_t w);
        s_valid <= 1'b1;
        s_cmd <= w.cmd;
        s_vox_x <= w.vx; s_vox_y <= w.vy; s_vox_z <= w.vz;
        s_center_value <= w.cv;
        s_neighbor_values <= w.nv;
        s_neighbor_present <= w.np;
        s_pixel_x <= w.pxl; s_pixel_y <= w.pyl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        zbuf_apply(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // write all six registers back to back, block idle
    task automatic write_regs(logic [63:0] rx, logic [63:0] ry, logic [63:0] rd,
                              logic [7:0] thr, logic [15:0] sw, logic [15:0] sh);
        logic [63:0] vals [6];
        vals[svzs_pkg::REG_ROW_X] = rx;
        vals[svzs_pkg::REG_ROW_Y] = ry;
        vals[svzs_pkg::REG_ROW_DEPTH] = rd;
        vals[svzs_pkg::REG_THRESHOLD] = {56'd0, thr};
        vals[svzs_pkg::REG_SPLAT_W] = {48'd0, sw};
        vals[svzs_pkg::REG_SPLAT_H] = {48'd0, sh};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[svzs_pkg::CFG_IDX_W-1:0];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            mdl_reg[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // projection row near unit scale so that splats land in a small window
    function automatic logic [63:0] near_row(int main);
        logic [15:0] c [4];
        for (int k = 0; k < 3; k++)
            c[k] = (k == main) ? 16'($urandom_range(2048, 6144))
                               : 16'($signed($urandom_range(0, 1023)) - 512);
        c[3] = 16'($signed($urandom_range(0, 128)) - 64);
        return {c[3], c[2], c[1], c[0]};
    endfunction

    function automatic voxel_word_t random_word();
        voxel_word_t w;
        int k;
        logic [7:0] thr;
        thr = mdl_reg[svzs_pkg::REG_THRESHOLD][7:0];
        w.cmd = ($urandom_range(0, 2) == 0) ? svzs_pkg::CMD_READ : svzs_pkg::CMD_SPLAT;
        w.vx = 9'($urandom_range(1, 40));
        w.vy = 9'($urandom_range(1, 40));
        w.vz = 9'($urandom_range(1, 256));
        if ($urandom_range(0, 9) == 0) begin
            w.vx = 9'($urandom); w.vy = 9'($urandom); w.vz = 9'($urandom);
        end
        w.cv = 8'($urandom);
        w.nv = 48'({$urandom, $urandom});
        w.np = 6'($urandom);
        w.pxl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 47));
        w.pyl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 47));
        // mostly a real surface voxel with random content
        if ($urandom_range(0, 3) != 0 && thr != 8'd255 && thr != 8'd0) begin
            k = $urandom_range(0, 5);
            w.cv = 8'($urandom_range(thr + 1, 255));
            w.nv[8*k +: 8] = 8'($urandom_range(0, thr - 1));
            w.np[k] = 1'b1;
        end
        return w;
    endfunction

    task automatic run_phase(int n, bit pressure);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (pressure && i == 20) hold_from = cyc;
            if (i == n/2) drain();
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end
            end
            burst--;
            send_word(random_word());
        end
        drain();
    endtask

    function automatic void add_row(logic cmd, int vx, int vy, int vz, int cv,
                                    logic [47:0] nv, logic [5:0] np, int pxl, int pyl,
                                    bit known, int d, int hx, int hy, int hz);
        table_row_t r;
        r.w.cmd = cmd;
        r.w.vx = 9'(vx); r.w.vy = 9'(vy); r.w.vz = 9'(vz);
        r.w.cv = 8'(cv); r.w.nv = nv; r.w.np = np;
        r.w.pxl = 8'(pxl); r.w.pyl = 8'(pyl);
        r.known = known;
        r.res.depth = 24'(d);
        r.res.hx = 9'(hx); r.res.hy = 9'(hy); r.res.hz = 9'(hz);
        directed.push_back(r);
    endfunction

    initial begin
        svzs_pkg::pix_t empty_pix;
        logic [63:0] big;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
        s_valid <= 1'b0; s_cmd <= svzs_pkg::CMD_SPLAT;
        s_vox_x <= '0; s_vox_y <= '0; s_vox_z <= '0;
        s_center_value <= '0; s_neighbor_values <= '0; s_neighbor_present <= '0;
        s_pixel_x <= '0; s_pixel_y <= '0;
        empty_pix.depth = svzs_pkg::EMPTY_DEPTH; empty_pix.hx = '0; empty_pix.hy = '0;
        empty_pix.hz = '0;
        for (int i = 0; i < IMG_W*IMG_H; i++) zbuf[i] = empty_pix;
        mdl_reg[svzs_pkg::REG_ROW_X] = svzs_pkg::ROW_X_RST;
        mdl_reg[svzs_pkg::REG_ROW_Y] = svzs_pkg::ROW_Y_RST;
        mdl_reg[svzs_pkg::REG_ROW_DEPTH] = svzs_pkg::ROW_DEPTH_RST;
        mdl_reg[svzs_pkg::REG_THRESHOLD] = {56'd0, svzs_pkg::THRESH_RST};
        mdl_reg[svzs_pkg::REG_SPLAT_W] = {48'd0, svzs_pkg::SPLAT_RST};
        mdl_reg[svzs_pkg::REG_SPLAT_H] = {48'd0, svzs_pkg::SPLAT_RST};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table under reset settings: each surface splat covers 2x2 pixels
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 0, 0, 1, 262144, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 255, 255, 1, 262144, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 1, 1, 1, 200, 48'd0, 6'h01, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 0, 0, 1, 256, 1, 1, 1);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 0, 0, 1, 262144, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 1, 1, 0, 0, 0, 0, 0);
        // center equal to threshold, neighbour equal to threshold, no neighbours
        add_row(svzs_pkg::CMD_SPLAT, 5, 5, 3, 128, 48'd0, 6'h3f, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 5, 5, 3, 129, {6{8'd128}}, 6'h3f, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 5, 5, 3, 255, 48'd0, 6'h00, 0, 0, 0, 0, 0, 0, 0);
        // nearer splat wins, farther one leaves the pixel alone
        add_row(svzs_pkg::CMD_SPLAT, 5, 5, 3, 255, 48'd0, 6'h20, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 5, 5, 2, 255, 48'd0, 6'h10, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 5, 5, 9, 255, 48'd0, 6'h04, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 4, 4, 1, 512, 5, 5, 2);
        // zero coordinate, clipped at the left edge
        add_row(svzs_pkg::CMD_SPLAT, 0, 3, 1, 255, 48'd0, 6'h02, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 0, 2, 1, 256, 0, 3, 1);
        // all fields at their maximum, then off the image
        add_row(svzs_pkg::CMD_SPLAT, 511, 511, 511, 255, {48{1'b1}}, 6'h3f, 255, 255,
                0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 511, 511, 511, 255, 48'hffff_ffff_ff00, 6'h3f, 0, 0,
                0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_SPLAT, 300, 10, 7, 255, 48'd0, 6'h01, 0, 0, 0, 0, 0, 0, 0);
        // far corner, clipped at the right and bottom edges
        add_row(svzs_pkg::CMD_SPLAT, 256, 256, 256, 255, 48'd0, 6'h08, 0, 0, 0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 255, 255, 1, 65536, 256, 256, 256);
        add_row(svzs_pkg::CMD_READ, 511, 511, 511, 255, {48{1'b1}}, 6'h3f, 1, 0,
                0, 0, 0, 0, 0);
        add_row(svzs_pkg::CMD_READ, 0, 0, 0, 0, 48'd0, 6'd0, 255, 0, 0, 0, 0, 0, 0);

        foreach (directed[i]) begin
            send_word(directed[i].w);
            if (directed[i].known) begin
                void'(pending_reads.pop_back());
                pending_reads.push_back(directed[i].res);
            end
        end
        drain();

        // reset values written back explicitly
        write_regs(svzs_pkg::ROW_X_RST, svzs_pkg::ROW_Y_RST, svzs_pkg::ROW_DEPTH_RST,
                   svzs_pkg::THRESH_RST, svzs_pkg::SPLAT_RST, svzs_pkg::SPLAT_RST);
        run_phase(100, 0);
        write_regs(near_row(0), near_row(1), near_row(2), 8'd100, 16'd9000, 16'd4096);
        run_phase(280, 1);
        // extent extremes
        write_regs(near_row(0), near_row(1), near_row(2), 8'd1, 16'd0, 16'd32768);
        run_phase(150, 0);
        write_regs(near_row(0), near_row(1), near_row(2), 8'd254, 16'd32768, 16'd0);
        run_phase(150, 0);
        // thresholds at which no voxel can be a surface
        write_regs(near_row(0), near_row(1), near_row(2), 8'd0, 16'd4137, 16'd4137);
        run_phase(40, 0);
        write_regs(near_row(0), near_row(1), near_row(2), 8'd255, 16'd4137, 16'd4137);
        run_phase(40, 0);
        // full-range rows and coefficient extremes
        big = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
        write_regs({$urandom, $urandom}, {$urandom, $urandom}, big,
                   8'($urandom_range(1, 254)), 16'($urandom), 16'($urandom));
        run_phase(80, 0);
        write_regs({16'h8000, 16'hffff, 16'hffff, 16'hffff}, {64{1'b1}},
                   {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 8'd128, 16'hffff, 16'd1);
        run_phase(60, 0);
        write_regs(near_row(0), near_row(1), near_row(2), 8'($urandom_range(20, 230)),
                   16'($urandom_range(0, 40000)), 16'($urandom_range(0, 40000)));
        run_phase(150, 1);

        if (n_err == 0) begin
            $display("surface_voxel_zbuffer_splat_tb OK");
        end else begin
            $display("surface_voxel_zbuffer_splat_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/svzs_pkg.sv
hdl/svzs_ram.sv
hdl/svzs_proj.sv
hdl/surface_voxel_zbuffer_splat.sv
dv/surface_voxel_zbuffer_splat_tb.sv
